[rtl/lrba_pkg.sv]
// Shared constants, types and ring helpers for the LED ring breathing animator.
`default_nettype none
package lrba_pkg;

    // Ring geometry and animation constants
    localparam int LED_COUNT   = 18;
    localparam int SPREAD      = 4;
    localparam int HALF_RING   = LED_COUNT / 2;
    localparam int IDX_W       = $clog2(LED_COUNT);
    localparam int K_W         = $clog2(SPREAD + 1);
    localparam int LEVEL_W     = 8;
    localparam int INDEX_W     = 5;
    localparam int LEVEL_STEP  = 3;
    localparam int ORIGIN_STEP = 2;
    localparam int LIMIT_RESET = 150;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [IDX_W:0]     idx_sum_t;
    typedef logic [K_W-1:0]     k_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [LEVEL_W:0]   level_sum_t;
    typedef logic [INDEX_W-1:0] index_t;

    // Offsets reduced around the ring at elaboration
    localparam idx_t SP_POS   = idx_t'(SPREAD % LED_COUNT);
    localparam idx_t SP_NEG   = idx_t'((LED_COUNT - (SPREAD % LED_COUNT)) % LED_COUNT);
    localparam idx_t HALF_OFS = idx_t'(HALF_RING % LED_COUNT);
    localparam idx_t ORG_OFS  = idx_t'(ORIGIN_STEP % LED_COUNT);
    localparam idx_t IDX_LAST = idx_t'(LED_COUNT - 1);

    // Register map (word index)
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_LIMIT_LEVEL = 1'b0;

    // Seed write slots
    typedef enum logic [1:0] {
        SEED_POS      = 2'd0,
        SEED_POS_OPP  = 2'd1,
        SEED_NEG      = 2'd2,
        SEED_NEG_OPP  = 2'd3
    } seed_slot_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic update;
        logic probe;
        logic step;
        logic seed;
        logic emit;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_last;
        logic k_last;
        logic match;
        logic seed_last;
        logic out_free;
    } status_t;

    // a + b around the ring, both below LED_COUNT
    function automatic idx_t ring_add(input idx_t a, input idx_t b);
        idx_sum_t s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= idx_sum_t'(LED_COUNT))
        begin
            s = s - idx_sum_t'(LED_COUNT);
        end
        return idx_t'(s);
    endfunction

    function automatic idx_t ring_inc(input idx_t a);
        return (a == IDX_LAST) ? '0 : a + idx_t'(1);
    endfunction

    function automatic idx_t ring_dec(input idx_t a);
        return (a == '0) ? IDX_LAST : a - idx_t'(1);
    endfunction

endpackage
`default_nettype wire

[rtl/lrba_ctrl.sv]
// Frame sequencer: update sweep, seed search, seed writes, output sweep.
`default_nettype none
module lrba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              tick,
    output logic              in_stall,
    input  lrba_pkg::status_t status,
    output lrba_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_SEED   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only take a request between frames
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && tick)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.probe = 1'b1;
                if (status.match)
                begin
                    state_next = ST_SEED;
                end
                else if (status.k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
                if (status.seed_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_update_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> state_reg == ST_UPDATE || state_reg == ST_SEARCH)
        else $error("update sweep left to an unexpected state");

    a_seed_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEED |=> state_reg == ST_SEED || state_reg == ST_EMIT)
        else $error("seed writes left to an unexpected state");

endmodule
`default_nettype wire

[rtl/lrba_dp.sv]
// Level store, ring pointers, phase state and output register.
`default_nettype none
module lrba_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lrba_pkg::cmd_t           cmd,
    output lrba_pkg::status_t        status,
    input  lrba_pkg::level_t         limit_level,
    input  logic                     out_stall,
    output logic                     out_valid,
    output lrba_pkg::index_t         led_index,
    output lrba_pkg::level_t         green_level,
    output logic                     last
);

    lrba_pkg::level_t levels_reg [lrba_pkg::LED_COUNT];
    logic             rising_reg;
    lrba_pkg::idx_t   origin_reg;
    lrba_pkg::idx_t   idx_reg;
    lrba_pkg::k_t     k_reg;
    logic [1:0]       seed_cnt_reg;
    lrba_pkg::idx_t   pos_reg;
    lrba_pkg::idx_t   neg_reg;
    logic             notdone_reg;

    logic             out_valid_reg;
    lrba_pkg::index_t led_index_reg;
    lrba_pkg::level_t green_level_reg;
    logic             last_reg;

    lrba_pkg::idx_t       rd_addr;
    lrba_pkg::level_t     rd_data;
    lrba_pkg::level_t     upd_level;
    lrba_pkg::level_sum_t climb;
    lrba_pkg::level_t     seed_val;
    lrba_pkg::idx_t       seed_addr;
    logic                 lvl_short;
    logic                 frame_done;
    logic                 idx_last;
    logic                 out_free;

    // Single read port: search probes at pos, sweeps at idx
    assign rd_addr  = cmd.probe ? pos_reg : idx_reg;
    assign rd_data  = levels_reg[rd_addr];
    assign idx_last = (idx_reg == lrba_pkg::IDX_LAST);
    assign out_free = !out_valid_reg || !out_stall;

    // Per-LED breathing step
    always_comb
    begin
        climb = {1'b0, rd_data} + lrba_pkg::level_sum_t'(lrba_pkg::LEVEL_STEP);
        if (rising_reg)
        begin
            if (rd_data == '0)
            begin
                upd_level = '0;
            end
            else if (rd_data < limit_level)
            begin
                upd_level = climb[lrba_pkg::LEVEL_W] ? '1 : climb[lrba_pkg::LEVEL_W-1:0];
            end
            else
            begin
                upd_level = limit_level;
            end
        end
        else
        begin
            if (rd_data >= limit_level)
            begin
                upd_level = limit_level;
            end
            else if (rd_data > lrba_pkg::level_t'(lrba_pkg::LEVEL_STEP))
            begin
                upd_level = rd_data - lrba_pkg::level_t'(lrba_pkg::LEVEL_STEP);
            end
            else
            begin
                upd_level = '0;
            end
        end
    end

    // Seed value and the four seed targets
    always_comb
    begin
        if (rising_reg)
        begin
            seed_val = lrba_pkg::level_t'(lrba_pkg::LEVEL_STEP);
        end
        else if (limit_level >= lrba_pkg::level_t'(lrba_pkg::LEVEL_STEP))
        begin
            seed_val = limit_level - lrba_pkg::level_t'(lrba_pkg::LEVEL_STEP);
        end
        else
        begin
            seed_val = '0;
        end
        case (lrba_pkg::seed_slot_t'(seed_cnt_reg))
            lrba_pkg::SEED_POS:     seed_addr = pos_reg;
            lrba_pkg::SEED_POS_OPP: seed_addr = lrba_pkg::ring_add(pos_reg, lrba_pkg::HALF_OFS);
            lrba_pkg::SEED_NEG:     seed_addr = neg_reg;
            lrba_pkg::SEED_NEG_OPP: seed_addr = lrba_pkg::ring_add(neg_reg, lrba_pkg::HALF_OFS);
            default:                seed_addr = pos_reg;
        endcase
    end

    // Phase-end test per LED, folded over the output sweep
    assign lvl_short  = rising_reg ? (rd_data < limit_level) : (rd_data != '0);
    assign frame_done = !(notdone_reg || lvl_short);

    // Status to controller
    always_comb
    begin
        status.idx_last  = idx_last;
        status.k_last    = (k_reg == lrba_pkg::k_t'(lrba_pkg::SPREAD));
        status.match     = rising_reg ? (rd_data == '0) : (rd_data == limit_level);
        status.seed_last = (lrba_pkg::seed_slot_t'(seed_cnt_reg) == lrba_pkg::SEED_NEG_OPP);
        status.out_free  = out_free;
    end

    // Level store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lrba_pkg::LED_COUNT; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            levels_reg[idx_reg] <= upd_level;
        end
        else if (cmd.seed)
        begin
            levels_reg[seed_addr] <= seed_val;
        end
    end

    // Counters, search pointers, phase and origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rising_reg   <= 1'b1;
            origin_reg   <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            seed_cnt_reg <= '0;
            pos_reg      <= '0;
            neg_reg      <= '0;
            notdone_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg      <= '0;
                k_reg        <= '0;
                seed_cnt_reg <= '0;
                notdone_reg  <= 1'b0;
                if (rising_reg)
                begin
                    pos_reg <= origin_reg;
                    neg_reg <= origin_reg;
                end
                else
                begin
                    pos_reg <= lrba_pkg::ring_add(origin_reg, lrba_pkg::SP_POS);
                    neg_reg <= lrba_pkg::ring_add(origin_reg, lrba_pkg::SP_NEG);
                end
            end
            if (cmd.update || cmd.emit)
            begin
                idx_reg <= idx_last ? '0 : idx_reg + lrba_pkg::idx_t'(1);
            end
            if (cmd.step)
            begin
                k_reg <= k_reg + lrba_pkg::k_t'(1);
                if (rising_reg)
                begin
                    pos_reg <= lrba_pkg::ring_inc(pos_reg);
                    neg_reg <= lrba_pkg::ring_dec(neg_reg);
                end
                else
                begin
                    pos_reg <= lrba_pkg::ring_dec(pos_reg);
                    neg_reg <= lrba_pkg::ring_inc(neg_reg);
                end
            end
            if (cmd.seed)
            begin
                seed_cnt_reg <= seed_cnt_reg + 2'd1;
            end
            if (cmd.emit)
            begin
                notdone_reg <= notdone_reg || lvl_short;
            end
            // Phase flip once the whole ring has reached its target
            if (cmd.finish && frame_done)
            begin
                rising_reg <= !rising_reg;
                if (!rising_reg)
                begin
                    origin_reg <= lrba_pkg::ring_add(origin_reg, lrba_pkg::ORG_OFS);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            led_index_reg   <= lrba_pkg::index_t'(idx_reg);
            green_level_reg <= rd_data;
            last_reg        <= idx_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_index   = led_index_reg;
    assign green_level = green_level_reg;
    assign last        = last_reg;

    a_origin_range: assert property (@(posedge clk) disable iff (!rst_n)
        origin_reg <= lrba_pkg::IDX_LAST)
        else $error("origin left the ring");

    a_finish_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> cmd.emit && idx_last)
        else $error("frame finished before the last LED was sent");

endmodule
`default_nettype wire

[rtl/led_ring_breathing_animator_top.sv]
// Top level of the LED ring breathing animator: config register and unit wiring.
//
// Usage: each request on the tick channel (in_valid / in_stall, field tick)
// with tick high runs one animation frame; a request with tick low is taken
// and does nothing. A frame sweeps all 18 levels through the update step,
// probes up to 5 seed candidates, writes 4 seed LEDs when a candidate
// matches, then sends 18 results on the output channel (out_valid /
// out_stall, fields led_index, green_level, last), one per cycle while the
// receiver does not stall, through a single output register, last set on
// the final LED. Every sweep and probe goes through the single read port of
// the level store. in_stall is high for the whole frame. When the receiver
// stalls, the output register holds its result and the sweep waits.
// Reset clears all levels, selects the rising phase, puts the origin at
// LED 0 and loads limit_level with 150. limit_level sits at byte address 0
// of the APB port; the user must see that it is written only between
// frames, as the block itself does not enforce this.
`default_nettype none
module led_ring_breathing_animator_top (
    input  logic        clk,
    input  logic        rst_n,
    // tick channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tick,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  led_index,
    output logic [7:0]  green_level,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lrba_pkg::level_t  limit_level_reg;
    lrba_pkg::cmd_t    cmd;
    lrba_pkg::status_t status;
    lrba_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_level_reg <= lrba_pkg::level_t'(lrba_pkg::LIMIT_RESET);
        end
        else if (cfg_wr && (reg_idx == lrba_pkg::REG_LIMIT_LEVEL))
        begin
            limit_level_reg <= pwdata[lrba_pkg::LEVEL_W-1:0];
        end
    end

    assign prdata = (reg_idx == lrba_pkg::REG_LIMIT_LEVEL)
                    ? {{(32-lrba_pkg::LEVEL_W){1'b0}}, limit_level_reg} : '0;

    lrba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .tick     (tick),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrba_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .limit_level (limit_level_reg),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .led_index   (led_index),
        .green_level (green_level),
        .last        (last)
    );

endmodule
`default_nettype wire
